// ===== hdl/ahfr_pkg.sv =====
// Package for the ASCII-hex frame receiver: frame constants, result layout,
// status codes and the character and CRC helper functions.
// No dependencies; used by ascii_hex_frame_receiver_unit.
`default_nettype none

package ahfr_pkg;

	// Frame layout.
	localparam int MAX_FRAME_BYTES = 128;
	localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
	localparam int LEN_CMP_W       = 9;
	localparam logic [15:0] START_MARK = 16'hA5B6;
	localparam logic [15:0] END_MARK   = 16'hB6A5;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [7:0]  VERSION_RESET = 8'h02;
	localparam int MIN_FRAME   = 13;
	localparam int HEADER_LEN  = 9;

	// Byte positions of the header fields.
	localparam int POS_ID     = 2;
	localparam int POS_TYPE   = 4;
	localparam int POS_CMD    = 5;
	localparam int POS_LENGTH = 7;
	localparam int POS_VER    = 8;

	// Result queue.
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	// Port widths.
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 72;
	localparam int CFG_W       = 8;

	// Blank characters.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_DROPPED     = 3'd1,
		ST_BAD_LENGTH  = 3'd2,
		ST_BAD_MARKER  = 3'd3,
		ST_BAD_VERSION = 3'd4,
		ST_BAD_CRC     = 3'd5
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	// Output tdata, lowest field last.
	typedef struct packed {
		logic [5:0]  pad;
		logic [7:0]  body_len;
		logic [15:0] command;
		logic [7:0]  msg_type;
		logic [15:0] node_addr;
		status_t     status;
		logic [6:0]  payload_index;
		logic [7:0]  payload_byte;
	} res_data_t;

	typedef struct packed {
		logic      last;
		kind_t     kind;
		res_data_t data;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] nib;
	} hex_t;

	// Hex digit decode.
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.valid = 1'b1;
		h.nib   = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.nib = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			h.nib = c[3:0] + 4'd9;
		end else begin
			h.valid = 1'b0;
		end
		return h;
	endfunction

	// One byte of CRC-16/Modbus, reflected, unrolled over eight bits.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ascii_hex_frame_receiver_unit.sv =====
// Top level of the ASCII-hex frame receiver: character decode, frame state,
// CRC check and a four-entry result queue. Depends on ahfr_pkg.
//
// Channel  Dir  Handshake                 Contents
// s_*      in   s_tvalid / s_tready       tdata = ascii_char, tlast = frame_end
// m_*      out  m_tvalid / m_tready       tdata = result fields, tuser = kind,
//                                         tlast = last_of_run
// cfg_*    in   cfg_valid / cfg_ready     cfg_data = expected_version
//
// One character is taken per cycle while s_tready is high; frame state is updated in the cycle it
// is accepted and its results enter the result queue at the same edge.
// Results leave one per cycle while m_tready is high, so a character that ends a frame and also
// completes a payload byte yields two results, the payload byte and then the summary.
// s_tready is high while at least two queue slots are free.
// Reset is asynchronous; stalls on m_tready
// fill the queue and then hold s_tready low.
`default_nettype none

module ascii_hex_frame_receiver_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [ahfr_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] ascii_char
	input  wire logic                                s_tlast,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// [7:0] payload_byte, [14:8] payload_index, [17:15] status,
	// [33:18] node_addr, [41:34] msg_type, [57:42] command,
	// [65:58] body_len, [71:66] zero
	output logic [ahfr_pkg::OUT_TDATA_W-1:0]         m_tdata,
	output logic                                     m_tuser,   // [0] kind
	output logic                                     m_tlast,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ahfr_pkg::CFG_W-1:0]          cfg_data
);
	import ahfr_pkg::*;

	// Frame state.
	logic [7:0]       expected_version_q;
	logic [3:0]       high_nibble_q;
	logic             have_high_q;
	logic             decode_failed_q;
	logic [CNT_W-1:0] byte_count_q;
	logic [15:0]      running_crc_q;
	logic [15:0]      start_word_q;
	logic [15:0]      header_id_q;
	logic [7:0]       header_type_q;
	logic [15:0]      header_command_q;
	logic [7:0]       header_length_q;
	logic [7:0]       header_version_q;
	logic [15:0]      received_crc_q;
	logic [15:0]      tail_word_q;

	// Next frame state before the end-of-frame clear.
	logic [3:0]       high_nibble_n;
	logic             have_high_n;
	logic             decode_failed_n;
	logic [CNT_W-1:0] byte_count_n;
	logic [15:0]      running_crc_n;
	logic [15:0]      start_word_n;
	logic [15:0]      header_id_n;
	logic [7:0]       header_type_n;
	logic [15:0]      header_command_n;
	logic [7:0]       header_length_n;
	logic [7:0]       header_version_n;
	logic [15:0]      received_crc_n;
	logic [15:0]      tail_word_n;

	logic             s_accept;
	logic [7:0]       ch;
	logic             blank;
	hex_t             hex;
	logic             byte_done;
	logic             overflow;
	logic [7:0]       new_byte;
	logic             in_crc_range;
	logic             emit;
	logic [CNT_W-1:0] pay_index;
	status_t          status;
	result_t          pay_res;
	result_t          sum_res;
	result_t          res0;
	logic             push0;
	logic             push1;

	// Result queue.
	result_t             rq_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_ptr_q;
	logic [RQ_PTR_W-1:0] rd_ptr_q;
	logic [RQ_CNT_W-1:0] rq_cnt_q;
	logic                m_accept;

	assign cfg_ready = 1'b1;
	assign s_tready  = (rq_cnt_q <= RQ_CNT_W'(RQ_DEPTH - 2));
	assign s_accept  = s_tvalid & s_tready;
	assign m_tvalid  = (rq_cnt_q != '0);
	assign m_accept  = m_tvalid & m_tready;
	assign m_tdata   = rq_q[rd_ptr_q].data;
	assign m_tuser   = rq_q[rd_ptr_q].kind;
	assign m_tlast   = rq_q[rd_ptr_q].last;

	// Character classification and byte assembly.
	assign ch        = s_tdata[7:0];
	assign blank     = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
	assign hex       = hex_decode(ch);
	assign byte_done = !blank && !decode_failed_q && hex.valid && have_high_q;
	assign new_byte  = {high_nibble_q, hex.nib};
	assign overflow  = (byte_count_q >= CNT_W'(MAX_FRAME_BYTES));
	assign in_crc_range = ({{(LEN_CMP_W-CNT_W){1'b0}}, byte_count_q} <
		({1'b0, header_length_q} + LEN_CMP_W'(HEADER_LEN)));
	assign emit      = byte_done && !overflow && in_crc_range &&
		(byte_count_q >= CNT_W'(HEADER_LEN));
	assign pay_index = byte_count_q - CNT_W'(HEADER_LEN);

	// Frame state update for one character.
	always_comb begin
		high_nibble_n    = high_nibble_q;
		have_high_n      = have_high_q;
		decode_failed_n  = decode_failed_q;
		byte_count_n     = byte_count_q;
		running_crc_n    = running_crc_q;
		start_word_n     = start_word_q;
		header_id_n      = header_id_q;
		header_type_n    = header_type_q;
		header_command_n = header_command_q;
		header_length_n  = header_length_q;
		header_version_n = header_version_q;
		received_crc_n   = received_crc_q;
		tail_word_n      = tail_word_q;
		if (!blank && !decode_failed_q) begin
			if (!hex.valid) begin
				decode_failed_n = 1'b1;
			end else if (!have_high_q) begin
				high_nibble_n = hex.nib;
				have_high_n   = 1'b1;
			end else begin
				have_high_n = 1'b0;
				if (overflow) begin
					decode_failed_n = 1'b1;
				end else begin
					if (byte_count_q < CNT_W'(POS_ID)) begin
						start_word_n = {start_word_q[7:0], new_byte};
					end else if (byte_count_q < CNT_W'(POS_TYPE)) begin
						header_id_n = {header_id_q[7:0], new_byte};
					end else if (byte_count_q == CNT_W'(POS_TYPE)) begin
						header_type_n = new_byte;
					end else if (byte_count_q < CNT_W'(POS_LENGTH)) begin
						header_command_n = {header_command_q[7:0], new_byte};
					end else if (byte_count_q == CNT_W'(POS_LENGTH)) begin
						header_length_n = new_byte;
					end else if (byte_count_q == CNT_W'(POS_VER)) begin
						header_version_n = new_byte;
					end
					if (in_crc_range) begin
						running_crc_n = crc_byte(running_crc_q, new_byte);
					end
					received_crc_n = {received_crc_q[7:0], tail_word_q[15:8]};
					tail_word_n    = {tail_word_q[7:0], new_byte};
					byte_count_n   = byte_count_q + CNT_W'(1);
				end
			end
		end
	end

	// Frame checks, in priority order.
	always_comb begin
		if (decode_failed_n || have_high_n || byte_count_n == '0) begin
			status = ST_DROPPED;
		end else if (byte_count_n < CNT_W'(MIN_FRAME)) begin
			status = ST_BAD_LENGTH;
		end else if (start_word_n != START_MARK || tail_word_n != END_MARK) begin
			status = ST_BAD_MARKER;
		end else if ({{(LEN_CMP_W-CNT_W){1'b0}}, byte_count_n} !=
				({1'b0, header_length_n} + LEN_CMP_W'(MIN_FRAME))) begin
			status = ST_BAD_LENGTH;
		end else if (header_version_n != expected_version_q) begin
			status = ST_BAD_VERSION;
		end else if (received_crc_n != running_crc_n) begin
			status = ST_BAD_CRC;
		end else begin
			status = ST_OK;
		end
	end

	// Result records.
	always_comb begin
		pay_res                    = '0;
		pay_res.kind               = KIND_PAYLOAD;
		pay_res.last               = !s_tlast;
		pay_res.data.payload_byte  = new_byte;
		pay_res.data.payload_index = pay_index[6:0];
		pay_res.data.status        = ST_OK;

		sum_res             = '0;
		sum_res.kind        = KIND_SUMMARY;
		sum_res.last        = 1'b1;
		sum_res.data.status = status;
		if (status != ST_DROPPED) begin
			sum_res.data.node_addr = header_id_n;
			sum_res.data.msg_type  = header_type_n;
			sum_res.data.command   = header_command_n;
			sum_res.data.body_len  = header_length_n;
		end

		res0  = emit ? pay_res : sum_res;
		push0 = s_accept && (emit || s_tlast);
		push1 = s_accept && emit && s_tlast;
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_version_q <= VERSION_RESET;
		end else if (cfg_valid && cfg_ready) begin
			expected_version_q <= cfg_data;
		end
	end

	// Frame state registers; the end of a frame returns them to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_nibble_q    <= '0;
			have_high_q      <= 1'b0;
			decode_failed_q  <= 1'b0;
			byte_count_q     <= '0;
			running_crc_q    <= CRC_INIT;
			start_word_q     <= '0;
			header_id_q      <= '0;
			header_type_q    <= '0;
			header_command_q <= '0;
			header_length_q  <= '0;
			header_version_q <= '0;
			received_crc_q   <= '0;
			tail_word_q      <= '0;
		end else if (s_accept) begin
			if (s_tlast) begin
				high_nibble_q    <= '0;
				have_high_q      <= 1'b0;
				decode_failed_q  <= 1'b0;
				byte_count_q     <= '0;
				running_crc_q    <= CRC_INIT;
				start_word_q     <= '0;
				header_id_q      <= '0;
				header_type_q    <= '0;
				header_command_q <= '0;
				header_length_q  <= '0;
				header_version_q <= '0;
				received_crc_q   <= '0;
				tail_word_q      <= '0;
			end else begin
				high_nibble_q    <= high_nibble_n;
				have_high_q      <= have_high_n;
				decode_failed_q  <= decode_failed_n;
				byte_count_q     <= byte_count_n;
				running_crc_q    <= running_crc_n;
				start_word_q     <= start_word_n;
				header_id_q      <= header_id_n;
				header_type_q    <= header_type_n;
				header_command_q <= header_command_n;
				header_length_q  <= header_length_n;
				header_version_q <= header_version_n;
				received_crc_q   <= received_crc_n;
				tail_word_q      <= tail_word_n;
			end
		end
	end

	// Result queue storage; up to two items are written per cycle.
	always_ff @(posedge clk) begin
		if (push0) begin
			rq_q[wr_ptr_q] <= res0;
		end
		if (push1) begin
			rq_q[wr_ptr_q + RQ_PTR_W'(1)] <= sum_res;
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			rq_cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_PTR_W'(push0) + RQ_PTR_W'(push1);
			if (m_accept) begin
				rd_ptr_q <= rd_ptr_q + RQ_PTR_W'(1);
			end
			rq_cnt_q <= rq_cnt_q + RQ_CNT_W'(push0) + RQ_CNT_W'(push1) -
				RQ_CNT_W'(m_accept);
		end
	end

endmodule

`default_nettype wire

// ===== bench/tb_ascii_hex_frame_receiver_unit.sv =====
`timescale 1ns / 100ps
// Testbench for ascii_hex_frame_receiver_unit: hex-text frames, clean and damaged,
// are streamed in and every result is checked against a behavioral decoder.
// Depends on ahfr_pkg and the receiver RTL; needs no files or arguments.

module tb_ascii_hex_frame_receiver_unit;
	import ahfr_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_CHARS  = 420;

	typedef struct {
		logic [7:0] ch;
		logic       fin;
	} char_item_t;

	typedef struct {
		kind_t       kind;
		logic [7:0]  pbyte;
		logic [6:0]  pidx;
		status_t     status;
		logic [15:0] dev_id;
		logic [7:0]  ftype;
		logic [15:0] cmd;
		logic [7:0]  plen;
		logic        last;
	} frame_result_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   s_tlast   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       cfg_data  = VERSION_RESET;

	ascii_hex_frame_receiver_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Stimulus and scoreboard storage.
	char_item_t    char_q[$];
	frame_result_t frame_results_due[$];
	int            err_count    = 0;
	int            cycle_cnt    = 0;
	int            cfg_writes   = 0;
	int            queued_chars = 0;
	int            payload_count = 0;
	int            status_counts[6];
	logic          char_taken   = 1'b0;
	logic [7:0]    tx_version   = VERSION_RESET;
	int            tx_gap       = 0;
	int            rx_stall     = 0;
	int            hold_left    = 0;
	logic          hold_req     = 1'b0;
	logic          tx_gaps_on   = 1'b1;
	logic          rx_gaps_on   = 1'b1;

	// Decoder state mirrored from the block's behavior.
	logic [7:0]  want_version = VERSION_RESET;
	logic [3:0]  hi_nib;
	logic        hi_pending;
	logic        frame_bad;
	int          nbytes;
	logic [15:0] crc_acc;
	logic [15:0] mark_head;
	logic [15:0] dev_id;
	logic [7:0]  ftype;
	logic [15:0] cmd_word;
	logic [7:0]  plen;
	logic [7:0]  ver_byte;
	logic [15:0] crc_field;
	logic [15:0] mark_tail;

	// Clock.
	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void restart_frame();
		hi_nib     = 4'h0;
		hi_pending = 1'b0;
		frame_bad  = 1'b0;
		nbytes     = 0;
		crc_acc    = CRC_INIT;
		mark_head  = 16'h0000;
		dev_id     = 16'h0000;
		ftype      = 8'h00;
		cmd_word   = 16'h0000;
		plen       = 8'h00;
		ver_byte   = 8'h00;
		crc_field  = 16'h0000;
		mark_tail  = 16'h0000;
	endfunction

	// Bit 4 flags a hex digit; bits 3:0 hold its value.
	function automatic logic [4:0] hex_digit(input logic [7:0] ch);
		if (ch >= "0" && ch <= "9")
			return {1'b1, 4'(ch - "0")};
		if (ch >= "A" && ch <= "F")
			return {1'b1, 4'(ch - "A" + 10)};
		if (ch >= "a" && ch <= "f")
			return {1'b1, 4'(ch - "a" + 10)};
		return 5'h00;
	endfunction

	function automatic logic is_blank(input logic [7:0] ch);
		return ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF;
	endfunction

	// Reflected CRC-16/Modbus, one byte at a time.
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] acc;
		acc = crc ^ {8'h00, b};
		repeat (8) acc = (acc >> 1) ^ (acc[0] ? CRC_POLY : 16'h0000);
		return acc;
	endfunction

	// Works out the results that one accepted character causes.
	function automatic void decode_char(input logic [7:0] ch, input logic fin);
		logic [4:0]    dig;
		logic [7:0]    b;
		logic          emit;
		int            pos;
		status_t       st;
		frame_result_t r;
		dig  = hex_digit(ch);
		emit = 1'b0;
		if (!is_blank(ch) && !frame_bad) begin
			if (!dig[4]) begin
				frame_bad = 1'b1;
			end else if (!hi_pending) begin
				hi_nib     = dig[3:0];
				hi_pending = 1'b1;
			end else begin
				b          = {hi_nib, dig[3:0]};
				hi_pending = 1'b0;
				pos        = nbytes;
				if (pos >= MAX_FRAME_BYTES) begin
					frame_bad = 1'b1;
				end else begin
					case (pos)
						0, 1: mark_head = {mark_head[7:0], b};
						2, 3: dev_id = {dev_id[7:0], b};
						4: ftype = b;
						5, 6: cmd_word = {cmd_word[7:0], b};
						7: plen = b;
						8: ver_byte = b;
						default: ;
					endcase
					if (pos < HEADER_LEN + int'(plen)) begin
						crc_acc = crc_step(crc_acc, b);
						emit    = (pos >= HEADER_LEN);
					end
					// The last four bytes slide through the CRC and end-marker words.
					crc_field = {crc_field[7:0], mark_tail[15:8]};
					mark_tail = {mark_tail[7:0], b};
					nbytes    = pos + 1;
				end
				if (emit) begin
					r = '{KIND_PAYLOAD, b, 7'(pos - HEADER_LEN), ST_OK,
						16'h0000, 8'h00, 16'h0000, 8'h00, !fin};
					frame_results_due.push_back(r);
					payload_count++;
				end
			end
		end
		if (fin) begin
			if (frame_bad || hi_pending || nbytes == 0)
				st = ST_DROPPED;
			else if (nbytes < MIN_FRAME)
				st = ST_BAD_LENGTH;
			else if (mark_head != START_MARK || mark_tail != END_MARK)
				st = ST_BAD_MARKER;
			else if (nbytes != MIN_FRAME + int'(plen))
				st = ST_BAD_LENGTH;
			else if (ver_byte != want_version)
				st = ST_BAD_VERSION;
			else if (crc_field != crc_acc)
				st = ST_BAD_CRC;
			else
				st = ST_OK;
			if (st == ST_DROPPED)
				r = '{KIND_SUMMARY, 8'h00, 7'h00, st, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b1};
			else
				r = '{KIND_SUMMARY, 8'h00, 7'h00, st, dev_id, ftype, cmd_word, plen, 1'b1};
			frame_results_due.push_back(r);
			status_counts[st]++;
			restart_frame();
		end
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("Field %s: expected %0h, got %0h", name, want, got);
			err_count++;
		end
	endfunction

	// Compares one accepted result with the oldest expectation.
	task automatic check_result();
		frame_result_t want;
		res_data_t     got;
		got = res_data_t'(m_tdata);
		if (frame_results_due.size() == 0) begin
			$error("Unexpected result: tdata %h, tuser %b, tlast %b", m_tdata, m_tuser, m_tlast);
			err_count++;
		end else begin
			want = frame_results_due.pop_front();
			check_field("kind", 16'(want.kind), 16'(m_tuser));
			check_field("payload_byte", 16'(want.pbyte), 16'(got.payload_byte));
			check_field("payload_index", 16'(want.pidx), 16'(got.payload_index));
			check_field("status", 16'(want.status), 16'(got.status));
			check_field("node_addr", want.dev_id, got.node_addr);
			check_field("msg_type", 16'(want.ftype), 16'(got.msg_type));
			check_field("command", want.cmd, got.command);
			check_field("body_len", 16'(want.plen), 16'(got.body_len));
			check_field("last_of_run", 16'(want.last), 16'(m_tlast));
		end
	endtask

	// Handshakes are observed at the rising edge.
	always @(posedge clk) begin
		cycle_cnt++;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				decode_char(s_tdata, s_tlast);
				char_taken = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				want_version = cfg_data;
				cfg_writes++;
			end
			if (m_tvalid && m_tready)
				check_result();
		end
	end

	// Mostly no gap, sometimes a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Character driver: offers the next queued item after each acceptance or gap.
	always @(negedge clk) begin : drive_chars
		char_item_t it;
		if (arst_n && (!s_tvalid || char_taken)) begin
			if (tx_gap > 0) begin
				s_tvalid <= 1'b0;
				tx_gap--;
			end else if (char_q.size() != 0) begin
				it = char_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= it.ch;
				s_tlast  <= it.fin;
				tx_gap = tx_gaps_on ? pick_gap() : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		char_taken = 1'b0;
	end

	// Result sink: random stalls plus an occasional long hold-off.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (rx_stall > 0) begin
				m_tready <= 1'b0;
				rx_stall--;
			end else begin
				m_tready <= 1'b1;
				if (rx_gaps_on)
					rx_stall = pick_gap();
			end
		end
	end

	// Run limit.
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
		$display("Timeout after %0d cycles", cycle_cnt);
		$display("DONE: errors detected");
		$finish;
	end

	task automatic push_char(input logic [7:0] ch, input logic fin);
		char_q.push_back('{ch, fin});
		queued_chars++;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 10)
			return 8'("0" + n);
		return ($urandom_range(0, 1) != 0) ? 8'("A" + n - 10) : 8'("a" + n - 10);
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	function automatic logic [7:0] bad_char();
		logic [7:0] c;
		logic [4:0] d;
		do begin
			c = 8'($urandom_range(0, 255));
			d = hex_digit(c);
		end while (d[4] || is_blank(c));
		return c;
	endfunction

	// One frame with random header and payload; some are damaged on purpose.
	task automatic random_frame();
		logic [7:0]  bytes[$];
		logic [7:0]  txt[$];
		logic [15:0] crc;
		int          len, n, r, k;
		r = $urandom_range(0, 99);
		len = (r < 3) ? $urandom_range(100, 127) : ((r < 15) ? 0 : $urandom_range(1, 12));
		bytes.push_back(START_MARK[15:8]);
		bytes.push_back(START_MARK[7:0]);
		repeat (5) bytes.push_back(8'($urandom_range(0, 255)));
		bytes.push_back(8'(len));
		bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : tx_version);
		repeat (len) bytes.push_back(8'($urandom_range(0, 255)));
		crc = CRC_INIT;
		foreach (bytes[i]) crc = crc_step(crc, bytes[i]);
		bytes.push_back(crc[15:8]);
		bytes.push_back(crc[7:0]);
		bytes.push_back(END_MARK[15:8]);
		bytes.push_back(END_MARK[7:0]);

		// Byte-level damage: flipped bit, truncation, trailing bytes, bogus length.
		r = $urandom_range(0, 99);
		if (r >= 70 && r < 76) begin
			k = $urandom_range(0, bytes.size() - 1);
			bytes[k] ^= 8'(1 << $urandom_range(0, 7));
		end else if (r >= 76 && r < 81) begin
			n = $urandom_range(1, bytes.size() - 1);
			repeat (n) void'(bytes.pop_back());
		end else if (r >= 81 && r < 84) begin
			repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom_range(0, 255)));
		end else if (r >= 84 && r < 87) begin
			bytes[7] = 8'($urandom_range(0, 255));
		end

		foreach (bytes[i]) begin
			if ($urandom_range(0, 19) == 0)
				txt.push_back(blank_char());
			txt.push_back(hex_char(bytes[i][7:4]));
			txt.push_back(hex_char(bytes[i][3:0]));
		end

		// Text-level damage: a stray character or a lost digit.
		if (r >= 87 && r < 92)
			txt.insert($urandom_range(0, txt.size()), bad_char());
		else if (r >= 92 && r < 96)
			txt.delete($urandom_range(0, txt.size() - 1));
		if ($urandom_range(0, 4) == 0)
			txt.push_back(blank_char());
		foreach (txt[i]) push_char(txt[i], i == txt.size() - 1);
	endtask

	// Arbitrary characters, with frame ends scattered through them.
	task automatic noise_burst();
		int n;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++)
			push_char(8'($urandom_range(0, 255)), (i == n - 1) || ($urandom_range(0, 7) == 0));
	endtask

	task automatic empty_frame();
		repeat ($urandom_range(0, 3)) push_char(blank_char(), 1'b0);
		push_char(blank_char(), 1'b1);
	endtask

	// Holds the write for exactly one accepting edge.
	task automatic set_version(input logic [7:0] v);
		tx_version = v;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every queued character is taken and every result has arrived.
	task automatic wait_idle();
		while (char_q.size() != 0 || s_tvalid || frame_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Main sequence.
	initial begin
		logic [7:0] versions[4];
		int         mark, r;
		restart_frame();
		foreach (status_counts[i]) status_counts[i] = 0;
		versions = '{8'hFF, 8'h00, 8'($urandom_range(1, 254)), VERSION_RESET};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: blanks, empty and odd frames, bad and boundary characters.
		push_char(CH_SPACE, 1'b1);
		push_char("A", 1'b0);
		push_char(CH_TAB, 1'b0);
		push_char("5", 1'b0);
		push_char(CH_CR, 1'b0);
		push_char("b", 1'b0);
		push_char(CH_LF, 1'b0);
		push_char("6", 1'b1);
		push_char("7", 1'b1);
		push_char(8'h00, 1'b0);
		push_char("1", 1'b1);
		push_char(8'hFF, 1'b1);
		push_char("0", 1'b0);
		push_char("9", 1'b0);
		push_char("f", 1'b0);
		push_char("F", 1'b0);
		push_char("c", 1'b0);
		push_char("D", 1'b1);
		push_char("@", 1'b1);
		push_char("g", 1'b1);
		push_char("/", 1'b0);
		push_char(":", 1'b1);
		wait_idle();

		// Random frames, noise bursts and empty frames under several version settings.
		for (int ph = 0; ph < 4; ph++) begin
			tx_gaps_on = (ph != 1);
			rx_gaps_on = (ph != 1);
			set_version(versions[ph]);
			mark = queued_chars;
			if (ph == 2)
				hold_req = 1'b1;
			while (queued_chars - mark < PHASE_CHARS) begin
				r = $urandom_range(0, 99);
				if (r < 86)
					random_frame();
				else if (r < 94)
					noise_burst();
				else
					empty_frame();
			end
			wait_idle();
		end

		if (frame_results_due.size() != 0) begin
			$error("%0d expected results never arrived", frame_results_due.size());
			err_count++;
		end
		$display("Run sent %0d characters and predicted %0d payload bytes with %0d version writes.",
			queued_chars, payload_count, cfg_writes);
		$display("Frame summaries: ok %0d, dropped %0d, length %0d, marker %0d, version %0d, crc %0d.",
			status_counts[ST_OK], status_counts[ST_DROPPED], status_counts[ST_BAD_LENGTH],
			status_counts[ST_BAD_MARKER], status_counts[ST_BAD_VERSION], status_counts[ST_BAD_CRC]);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
